// ===== hw/rtl/slbb_pkg.sv =====
// types and constants shared by the status led and buzzer blinker
`timescale 1ns / 1ps

package slbb_pkg;

    localparam int CFG_WIDTH = 8;
    localparam int CFG_INDEX_WIDTH = 2;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HEALTH_TOGGLE  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NETWORK_TOGGLE = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BUZZER_PERIOD  = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BUZZER_SOUND   = 2'd3;

    // register reset values
    localparam logic [CFG_WIDTH-1:0] HEALTH_TOGGLE_RESET  = 8'd2;
    localparam logic [CFG_WIDTH-1:0] NETWORK_TOGGLE_RESET = 8'd10;
    localparam logic [CFG_WIDTH-1:0] BUZZER_PERIOD_RESET  = 8'd10;
    localparam logic [CFG_WIDTH-1:0] BUZZER_SOUND_RESET   = 8'd2;

    // recognized command bytes
    localparam logic [7:0] CMD_ABNORMAL  = 8'h59; // Y
    localparam logic [7:0] CMD_ALARM     = 8'h52; // R
    localparam logic [7:0] CMD_NORMAL    = 8'h4E; // N
    localparam logic [7:0] CMD_CONNECTED = 8'h43; // C
    localparam logic [7:0] CMD_NOSERVICE = 8'h44; // D
    localparam logic [7:0] CMD_OFFLINE   = 8'h4F; // O

    typedef enum logic [1:0] {
        HM_NORMAL   = 2'd0,
        HM_ABNORMAL = 2'd1,
        HM_ALARM    = 2'd2
    } health_mode_t;

    typedef enum logic [1:0] {
        NM_OFFLINE   = 2'd0,
        NM_NOSERVICE = 2'd1,
        NM_CONNECTED = 2'd2
    } network_mode_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] health_toggle_ticks;
        logic [CFG_WIDTH-1:0] network_toggle_ticks;
        logic [CFG_WIDTH-1:0] buzzer_period_ticks;
        logic [CFG_WIDTH-1:0] buzzer_sound_ticks;
    } cfg_t;

    typedef struct packed {
        logic       command_valid;
        logic [7:0] command;
    } cmd_t;

    typedef struct packed {
        logic       yellow_led;
        logic       red_led;
        logic       buzzer_level;
        logic       blue_led;
        logic [1:0] health_mode_now;
        logic [1:0] network_mode_now;
    } led_t;

endpackage

// ===== hw/rtl/slbb_cfg.sv =====
// configuration registers of the blinker
`timescale 1ns / 1ps

module slbb_cfg
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [slbb_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [slbb_pkg::CFG_WIDTH-1:0]        cfg_data,
    output slbb_pkg::cfg_t                        cfg
);

    slbb_pkg::cfg_t cfg_reg;
    slbb_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                slbb_pkg::REG_HEALTH_TOGGLE:  cfg_next.health_toggle_ticks  = cfg_data;
                slbb_pkg::REG_NETWORK_TOGGLE: cfg_next.network_toggle_ticks = cfg_data;
                slbb_pkg::REG_BUZZER_PERIOD:  cfg_next.buzzer_period_ticks  = cfg_data;
                slbb_pkg::REG_BUZZER_SOUND:   cfg_next.buzzer_sound_ticks   = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.health_toggle_ticks  <= slbb_pkg::HEALTH_TOGGLE_RESET;
            cfg_reg.network_toggle_ticks <= slbb_pkg::NETWORK_TOGGLE_RESET;
            cfg_reg.buzzer_period_ticks  <= slbb_pkg::BUZZER_PERIOD_RESET;
            cfg_reg.buzzer_sound_ticks   <= slbb_pkg::BUZZER_SOUND_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/slbb_core.sv =====
// mode, counter and pin state with the per-tick update logic
`timescale 1ns / 1ps

module slbb_core
#(
    parameter int TICK_COUNT_WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  slbb_pkg::cmd_t   item,
    input  slbb_pkg::cfg_t   cfg,
    output slbb_pkg::led_t   result
);

    localparam int CMP_W = (TICK_COUNT_WIDTH > slbb_pkg::CFG_WIDTH) ?
                           TICK_COUNT_WIDTH : slbb_pkg::CFG_WIDTH;
    localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = '1;

    slbb_pkg::health_mode_t        health_mode_reg, health_mode_next;
    slbb_pkg::network_mode_t       network_mode_reg, network_mode_next;
    logic                          health_phase_reg, health_phase_next;
    logic                          network_phase_reg, network_phase_next;
    logic [TICK_COUNT_WIDTH-1:0]   health_ticks_reg, health_ticks_next;
    logic [TICK_COUNT_WIDTH-1:0]   network_ticks_reg, network_ticks_next;
    logic [TICK_COUNT_WIDTH-1:0]   buzzer_ticks_reg, buzzer_ticks_next;
    logic                          yellow_reg, yellow_next;
    logic                          red_reg, red_next;
    logic                          blue_reg, blue_next;
    logic                          buzzer_reg, buzzer_next;
    logic                          health_toggle;

    always_comb
    begin
        health_mode_next   = health_mode_reg;
        network_mode_next  = network_mode_reg;
        health_phase_next  = health_phase_reg;
        network_phase_next = network_phase_reg;
        health_ticks_next  = health_ticks_reg;
        network_ticks_next = network_ticks_reg;
        buzzer_ticks_next  = buzzer_ticks_reg;
        yellow_next        = yellow_reg;
        red_next           = red_reg;
        blue_next          = blue_reg;
        buzzer_next        = buzzer_reg;
        health_toggle      = 1'b0;

        // command byte first: a mode select clears that side's blink state
        if (item.command_valid)
        begin
            case (item.command)
                slbb_pkg::CMD_ABNORMAL,
                slbb_pkg::CMD_ALARM,
                slbb_pkg::CMD_NORMAL:
                begin
                    if (item.command == slbb_pkg::CMD_ABNORMAL)
                        health_mode_next = slbb_pkg::HM_ABNORMAL;
                    else if (item.command == slbb_pkg::CMD_ALARM)
                        health_mode_next = slbb_pkg::HM_ALARM;
                    else
                        health_mode_next = slbb_pkg::HM_NORMAL;
                    health_phase_next = 1'b0;
                    health_ticks_next = '0;
                end
                slbb_pkg::CMD_CONNECTED,
                slbb_pkg::CMD_NOSERVICE,
                slbb_pkg::CMD_OFFLINE:
                begin
                    if (item.command == slbb_pkg::CMD_CONNECTED)
                        network_mode_next = slbb_pkg::NM_CONNECTED;
                    else if (item.command == slbb_pkg::CMD_NOSERVICE)
                        network_mode_next = slbb_pkg::NM_NOSERVICE;
                    else
                        network_mode_next = slbb_pkg::NM_OFFLINE;
                    network_phase_next = 1'b0;
                    network_ticks_next = '0;
                end
                default:
                begin
                    health_mode_next = health_mode_reg;
                end
            endcase
        end

        case (health_mode_next)
            slbb_pkg::HM_ABNORMAL,
            slbb_pkg::HM_ALARM:
            begin
                health_toggle = CMP_W'(health_ticks_next) >= CMP_W'(cfg.health_toggle_ticks);
                if (health_toggle)
                begin
                    health_ticks_next = '0;
                    health_phase_next = ~health_phase_next;
                end
                if (health_mode_next == slbb_pkg::HM_ABNORMAL)
                begin
                    red_next    = 1'b0;
                    buzzer_next = 1'b1;
                    if (health_toggle)
                        yellow_next = health_phase_next;
                end
                else
                begin
                    yellow_next = 1'b0;
                    if (health_toggle)
                        red_next = health_phase_next;
                    if (CMP_W'(buzzer_ticks_next) >= CMP_W'(cfg.buzzer_period_ticks))
                        buzzer_ticks_next = '0;
                    // pin low means sounding
                    buzzer_next = !(CMP_W'(buzzer_ticks_next) < CMP_W'(cfg.buzzer_sound_ticks));
                end
            end
            default:
            begin
                yellow_next       = 1'b0;
                red_next          = 1'b0;
                buzzer_next       = 1'b1;
                health_phase_next = 1'b0;
            end
        endcase

        case (network_mode_next)
            slbb_pkg::NM_CONNECTED:
            begin
                blue_next          = 1'b1;
                network_phase_next = 1'b1;
            end
            slbb_pkg::NM_NOSERVICE:
            begin
                if (CMP_W'(network_ticks_next) >= CMP_W'(cfg.network_toggle_ticks))
                begin
                    network_ticks_next = '0;
                    network_phase_next = ~network_phase_next;
                    blue_next          = network_phase_next;
                end
                if (network_ticks_next != TICK_MAX)
                    network_ticks_next = network_ticks_next + 1'b1;
            end
            default:
            begin
                blue_next          = 1'b0;
                network_phase_next = 1'b0;
                network_ticks_next = '0;
            end
        endcase

        // saturating counters
        if (health_ticks_next != TICK_MAX)
            health_ticks_next = health_ticks_next + 1'b1;
        if (buzzer_ticks_next != TICK_MAX)
            buzzer_ticks_next = buzzer_ticks_next + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            health_mode_reg   <= slbb_pkg::HM_NORMAL;
            network_mode_reg  <= slbb_pkg::NM_OFFLINE;
            health_phase_reg  <= 1'b0;
            network_phase_reg <= 1'b0;
            health_ticks_reg  <= '0;
            network_ticks_reg <= '0;
            buzzer_ticks_reg  <= '0;
            yellow_reg        <= 1'b0;
            red_reg           <= 1'b0;
            blue_reg          <= 1'b0;
            buzzer_reg        <= 1'b1;
        end
        else if (fire)
        begin
            health_mode_reg   <= health_mode_next;
            network_mode_reg  <= network_mode_next;
            health_phase_reg  <= health_phase_next;
            network_phase_reg <= network_phase_next;
            health_ticks_reg  <= health_ticks_next;
            network_ticks_reg <= network_ticks_next;
            buzzer_ticks_reg  <= buzzer_ticks_next;
            yellow_reg        <= yellow_next;
            red_reg           <= red_next;
            blue_reg          <= blue_next;
            buzzer_reg        <= buzzer_next;
        end
    end

    always_comb
    begin
        result.yellow_led       = yellow_next;
        result.red_led          = red_next;
        result.buzzer_level     = buzzer_next;
        result.blue_led         = blue_next;
        result.health_mode_now  = health_mode_next;
        result.network_mode_now = network_mode_next;
    end

endmodule

// ===== hw/rtl/status_led_buzzer_blinker_unit.sv =====
// top level of the status led and buzzer blinker
`timescale 1ns / 1ps

// status led and buzzer blinker
// cmd channel: one transfer per tick; cmd_data carries an optional
// command byte (Y R N pick the health mode, C D O pick the network mode,
// anything else is ignored)
// led channel: one transfer per tick with the pin levels after that tick
// (buzzer_level low means sounding) and the two current modes
// cfg port: cfg_we writes cfg_data into the register at cfg_index
// (0 health toggle, 1 network toggle, 2 buzzer period, 3 buzzer sound);
// write it only while no tick is in flight
// a tick taken on cmd is held in the input register; its result is computed
// combinationally and captured in the output register once that register
// frees up, which raises led_valid
// throughput: one tick per cycle while led does not stall, set by the state update loop
// a stall on led holds the output register; cmd keeps flowing into the input
// register until both are full, then cmd_stall goes high
// reset: modes normal and offline, all counters zero, leds off, buzzer silent,
// registers at their defaults, both stages empty
module status_led_buzzer_blinker_unit
#(
    parameter int TICK_COUNT_WIDTH = 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_stall,
    input  slbb_pkg::cmd_t                        cmd_data,
    output logic                                  led_valid,
    input  logic                                  led_stall,
    output slbb_pkg::led_t                        led_data,
    input  logic                                  cfg_we,
    input  logic [slbb_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [slbb_pkg::CFG_WIDTH-1:0]        cfg_data
);

    slbb_pkg::cfg_t  cfg;
    slbb_pkg::cmd_t  cmd_data_reg;
    slbb_pkg::led_t  result;
    slbb_pkg::led_t  led_data_reg;
    logic            cmd_valid_reg, cmd_valid_next;
    logic            led_valid_reg, led_valid_next;
    logic            advance;
    logic            accept;
    logic            fire;

    slbb_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slbb_core
    #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (cmd_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    // output register frees up when empty or when its transfer completes
    assign advance   = !led_valid_reg || !led_stall;
    assign fire      = cmd_valid_reg && advance;
    assign cmd_stall = cmd_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (accept)
            cmd_valid_next = 1'b1;
        else if (fire)
            cmd_valid_next = 1'b0;

        led_valid_next = led_valid_reg;
        if (fire)
            led_valid_next = 1'b1;
        else if (!led_stall)
            led_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            led_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            led_valid_reg <= led_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_data_reg <= cmd_data;
        if (fire)
            led_data_reg <= result;
    end

    assign led_valid = led_valid_reg;
    assign led_data  = led_data_reg;

`ifndef SYNTHESIS
    property p_normal_quiet;
        @(posedge clk) disable iff (!rst_n)
        led_valid && (led_data.health_mode_now == slbb_pkg::HM_NORMAL) |->
            !led_data.yellow_led && !led_data.red_led && led_data.buzzer_level;
    endproperty
    a_normal_quiet: assert property (p_normal_quiet)
        else $error("leds or buzzer active in normal mode");

    property p_one_health_lamp;
        @(posedge clk) disable iff (!rst_n)
        led_valid |-> !(led_data.yellow_led && led_data.red_led);
    endproperty
    a_one_health_lamp: assert property (p_one_health_lamp)
        else $error("yellow and red lit together");

    property p_buzzer_alarm_only;
        @(posedge clk) disable iff (!rst_n)
        led_valid && !led_data.buzzer_level |->
            led_data.health_mode_now == slbb_pkg::HM_ALARM;
    endproperty
    a_buzzer_alarm_only: assert property (p_buzzer_alarm_only)
        else $error("buzzer sounding outside alarm mode");

    property p_blue_follows_mode;
        @(posedge clk) disable iff (!rst_n)
        led_valid && (led_data.network_mode_now != slbb_pkg::NM_NOSERVICE) |->
            led_data.blue_led == (led_data.network_mode_now == slbb_pkg::NM_CONNECTED);
    endproperty
    a_blue_follows_mode: assert property (p_blue_follows_mode)
        else $error("blue led does not match steady network mode");

    property p_stall_holds_result;
        @(posedge clk) disable iff (!rst_n)
        led_valid && led_stall |-> !fire ##1 (led_valid && $stable(led_data));
    endproperty
    a_stall_holds_result: assert property (p_stall_holds_result)
        else $error("result changed or state advanced under stall");
`endif

endmodule
